// ===== design/bmh_pkg.sv =====
package bmh_pkg;

  // Field widths of the stream payloads.
  localparam int KEY_W      = 32;
  localparam int POS_W      = 6;
  localparam int COUNT_W    = 7;
  localparam int STATUS_W   = 2;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // Operation carried in the input tuser field.
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT  = 2'd0,
    KIND_EXTRACT = 2'd1,
    KIND_DELETE  = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_WRITE_KEY,
    OP_READ_PARENT,
    OP_UP_STEP,
    OP_MOVE_PARENT,
    OP_READ_ENDS,
    OP_LOAD_ENDS,
    OP_READ_KIDS,
    OP_DOWN_STEP,
    OP_LOAD_OUT
  } dp_op_e;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic bad_pos;
    logic idx_zero;
    logic up_less;
    logic dn_more;
    logic dn_moved;
  } dp_stat_t;

endpackage

// ===== design/bmh_datapath.sv =====
module bmh_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bmh_pkg::dp_op_e                      op_i,
  input  bmh_pkg::kind_e                       kind_i,
  input  logic signed [bmh_pkg::KEY_W-1:0]     key_i,
  input  logic [bmh_pkg::POS_W-1:0]            pos_i,
  output bmh_pkg::dp_stat_t                    stat_o,
  output logic signed [bmh_pkg::KEY_W-1:0]     out_value_o,
  output bmh_pkg::status_e                     out_status_o,
  output logic [bmh_pkg::COUNT_W-1:0]          out_count_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (CW > bmh_pkg::POS_W) ? CW : bmh_pkg::POS_W;

  logic signed [bmh_pkg::KEY_W-1:0] heap_mem_q [CAPACITY];
  logic signed [bmh_pkg::KEY_W-1:0] rd0_q, rd1_q;
  logic signed [bmh_pkg::KEY_W-1:0] key_q, key_d, value_q, value_d, best;
  logic signed [bmh_pkg::KEY_W-1:0] wdata;
  logic [IW-1:0]   idx_q, idx_d, parent, waddr, raddr0, raddr1, last_idx;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [IW+1:0]   l_w, r_w, cnt_w;
  logic [PW-1:0]   pos_w, cnt_p;
  bmh_pkg::kind_e   kind_q, kind_d;
  bmh_pkg::status_e status_q, status_d;
  logic            we, l_ok, r_ok, l_less, pick_l, pick_r, up_less, full, empty, bad_pos;
  logic signed [bmh_pkg::KEY_W-1:0] out_value_q;
  bmh_pkg::status_e                 out_status_q;
  logic [bmh_pkg::COUNT_W-1:0]      out_count_q;

  // Tree navigation and comparisons around the moving key.
  always_comb begin
    parent   = IW'((idx_q - IW'(1)) >> 1);
    l_w      = {1'b0, idx_q, 1'b1};
    r_w      = l_w + (IW+2)'(1);
    cnt_w    = (IW+2)'(cnt_q);
    l_ok     = l_w < cnt_w;
    r_ok     = r_w < cnt_w;
    up_less  = key_q < rd0_q;
    l_less   = rd0_q < key_q;
    best     = l_less ? rd0_q : key_q;
    pick_r   = r_ok && (rd1_q < best);
    pick_l   = l_less && !pick_r;
    last_idx = (cnt_q == '0) ? '0 : IW'(cnt_q - CW'(1));
    pos_w    = PW'(pos_i);
    cnt_p    = PW'(cnt_q);
    full     = cnt_q >= CW'(CAPACITY);
    empty    = cnt_q == '0;
    bad_pos  = pos_w >= cnt_p;
  end

  assign stat_o = '{full: full, empty: empty, bad_pos: bad_pos, idx_zero: idx_q == '0,
                    up_less: up_less, dn_more: l_ok, dn_moved: pick_l || pick_r};

  // Command decode: memory accesses and next register values.
  always_comb begin
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = key_q;
    raddr0   = '0;
    raddr1   = '0;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    key_d    = key_q;
    value_d  = value_q;
    status_d = status_q;
    kind_d   = kind_q;
    case (op_i)
      bmh_pkg::OP_ACCEPT: begin
        kind_d   = kind_i;
        key_d    = key_i;
        value_d  = '0;
        status_d = bmh_pkg::ST_OK;
        raddr0   = '0;
        raddr1   = last_idx;
        case (kind_i)
          bmh_pkg::KIND_INSERT: begin
            if (full) begin
              status_d = bmh_pkg::ST_FULL;
            end else begin
              idx_d = IW'(cnt_q);
              cnt_d = cnt_q + CW'(1);
            end
          end
          bmh_pkg::KIND_EXTRACT: begin
            if (empty) begin
              status_d = bmh_pkg::ST_EMPTY;
              value_d  = '1;
            end
          end
          bmh_pkg::KIND_DELETE: begin
            if (bad_pos) begin
              status_d = bmh_pkg::ST_BADIDX;
            end else begin
              idx_d = pos_w[IW-1:0];
            end
          end
          default: ;
        endcase
      end
      bmh_pkg::OP_WRITE_KEY: begin
        we = 1'b1;
      end
      bmh_pkg::OP_READ_PARENT: begin
        raddr0 = parent;
      end
      bmh_pkg::OP_UP_STEP: begin
        we = 1'b1;
        if (up_less) begin
          wdata = rd0_q;
          idx_d = parent;
        end
      end
      bmh_pkg::OP_MOVE_PARENT: begin
        // Deletion pulls each ancestor down one level unconditionally.
        we    = 1'b1;
        wdata = rd0_q;
        idx_d = parent;
      end
      bmh_pkg::OP_READ_ENDS: begin
        raddr0 = '0;
        raddr1 = last_idx;
      end
      bmh_pkg::OP_LOAD_ENDS: begin
        if (kind_q == bmh_pkg::KIND_EXTRACT) begin
          value_d = rd0_q;
        end
        key_d = rd1_q;
        cnt_d = cnt_q - CW'(1);
        idx_d = '0;
      end
      bmh_pkg::OP_READ_KIDS: begin
        raddr0 = l_w[IW-1:0];
        raddr1 = r_ok ? r_w[IW-1:0] : '0;
      end
      bmh_pkg::OP_DOWN_STEP: begin
        we = 1'b1;
        if (pick_r) begin
          wdata = rd1_q;
          idx_d = r_w[IW-1:0];
        end else if (pick_l) begin
          wdata = rd0_q;
          idx_d = l_w[IW-1:0];
        end
      end
      default: ;
    endcase
  end

  // Heap storage: one write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem_q[waddr] <= wdata;
    end
    rd0_q <= heap_mem_q[raddr0];
    rd1_q <= heap_mem_q[raddr1];
  end

  // Fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    key_q    <= key_d;
    value_q  <= value_d;
    status_q <= status_d;
    kind_q   <= kind_d;
    if (op_i == bmh_pkg::OP_LOAD_OUT) begin
      out_value_q  <= value_q;
      out_status_q <= status_q;
      out_count_q  <= bmh_pkg::COUNT_W'(cnt_q);
    end
  end

  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;
  assign out_count_o  = out_count_q;

  // The fill count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  // A parent is only read for a position below the root.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == bmh_pkg::OP_READ_PARENT |-> idx_q != '0)
    else $error("parent read at the root");

endmodule

// ===== design/bmh_ctrl.sv =====
module bmh_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  bmh_pkg::kind_e     kind_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  bmh_pkg::dp_stat_t  stat_i,
  output bmh_pkg::dp_op_e    op_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UP     = 4'd1;
  localparam logic [3:0] S_UP_CMP = 4'd2;
  localparam logic [3:0] S_DEL    = 4'd3;
  localparam logic [3:0] S_DEL_MV = 4'd4;
  localparam logic [3:0] S_LOAD   = 4'd5;
  localparam logic [3:0] S_DN     = 4'd6;
  localparam logic [3:0] S_DN_CMP = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Sequencing of the sift operations.
  always_comb begin
    state_d    = state_q;
    op_o       = bmh_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o = bmh_pkg::OP_ACCEPT;
          case (kind_i)
            bmh_pkg::KIND_INSERT:  state_d = stat_i.full ? S_FIN : S_UP;
            bmh_pkg::KIND_EXTRACT: state_d = stat_i.empty ? S_FIN : S_LOAD;
            bmh_pkg::KIND_DELETE:  state_d = stat_i.bad_pos ? S_FIN : S_DEL;
            default:               state_d = S_FIN;
          endcase
        end
      end
      S_UP: begin
        if (stat_i.idx_zero) begin
          op_o    = bmh_pkg::OP_WRITE_KEY;
          state_d = S_FIN;
        end else begin
          op_o    = bmh_pkg::OP_READ_PARENT;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        op_o    = bmh_pkg::OP_UP_STEP;
        state_d = stat_i.up_less ? S_UP : S_FIN;
      end
      S_DEL: begin
        if (stat_i.idx_zero) begin
          op_o    = bmh_pkg::OP_READ_ENDS;
          state_d = S_LOAD;
        end else begin
          op_o    = bmh_pkg::OP_READ_PARENT;
          state_d = S_DEL_MV;
        end
      end
      S_DEL_MV: begin
        op_o    = bmh_pkg::OP_MOVE_PARENT;
        state_d = S_DEL;
      end
      S_LOAD: begin
        op_o    = bmh_pkg::OP_LOAD_ENDS;
        state_d = S_DN;
      end
      S_DN: begin
        if (stat_i.dn_more) begin
          op_o    = bmh_pkg::OP_READ_KIDS;
          state_d = S_DN_CMP;
        end else begin
          op_o    = bmh_pkg::OP_WRITE_KEY;
          state_d = S_FIN;
        end
      end
      S_DN_CMP: begin
        op_o    = bmh_pkg::OP_DOWN_STEP;
        state_d = stat_i.dn_moved ? S_DN : S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          op_o    = bmh_pkg::OP_LOAD_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // The result register is full from its load until the result is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (op_o == bmh_pkg::OP_LOAD_OUT) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // An accepted request always starts work away from idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != S_IDLE)
    else $error("accepted request left the controller idle");

  // Finishing with a free result register always presents a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && out_free |=> out_valid_q && state_q == S_IDLE)
    else $error("result not presented on finish");

endmodule

// ===== design/binary_min_heap_top.sv =====
// Binary min-heap priority queue of signed 32-bit keys held in a single-write,
// dual-read memory of CAPACITY entries. Each request (insert, extract minimum,
// delete at position) gives one result with value, status and the count after
// the operation. The block works on one request at a time. It takes the next
// one in the cycle after the previous result is loaded, even while that result
// still waits in the output register. Each tree level of a sift takes a read
// state and a step state, since the memory reads are registered. Error cases
// and the unused kind skip the sift and go straight to the finish state. A
// finished result that finds the output register still full waits until the
// held result is taken. The heap memory is not cleared at reset; only entries
// below the count are used.
module binary_min_heap_top #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // Bits from low: key[31:0], position[37:32], zero[39:38].
  input  logic [bmh_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // Bits from low: kind[1:0].
  input  logic [bmh_pkg::KIND_W-1:0]         s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // Bits from low: value[31:0], status[33:32], count[40:34], zero[47:41].
  output logic [bmh_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);

  bmh_pkg::dp_op_e                  op;
  bmh_pkg::dp_stat_t                stat;
  bmh_pkg::kind_e                   kind;
  logic signed [bmh_pkg::KEY_W-1:0] out_value;
  bmh_pkg::status_e                 out_status;
  logic [bmh_pkg::COUNT_W-1:0]      out_count;

  assign kind = bmh_pkg::kind_e'(s_axis_tuser_i);

  bmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .kind_i      (kind),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .op_o        (op)
  );

  bmh_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .kind_i       (kind),
    .key_i        (s_axis_tdata_i[bmh_pkg::KEY_W-1:0]),
    .pos_i        (s_axis_tdata_i[bmh_pkg::KEY_W +: bmh_pkg::POS_W]),
    .stat_o       (stat),
    .out_value_o  (out_value),
    .out_status_o (out_status),
    .out_count_o  (out_count)
  );

  // Pack the result fields, lowest first.
  assign m_axis_tdata_o = bmh_pkg::OUT_DATA_W'({out_count, out_status, out_value});

endmodule

// ===== sim/heap_result_checker.sv =====
// Watches both stream channels of the heap block. Each accepted request is run
// through a local copy of the heap to predict its result. Each accepted result
// is then compared with the oldest prediction.
module heap_result_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [bmh_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input  logic [bmh_pkg::KIND_W-1:0]     s_tuser_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [bmh_pkg::OUT_DATA_W-1:0] m_tdata_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             fill_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bmh_pkg::KEY_W-1:0] MOST_NEG_KEY = {1'b1, {(bmh_pkg::KEY_W-1){1'b0}}};

  typedef struct packed {
    logic [bmh_pkg::KEY_W-1:0]   value;
    bmh_pkg::status_e            status;
    logic [bmh_pkg::COUNT_W-1:0] count;
  } heap_result_t;

  // Shadow heap and the results still owed by the block.
  logic [bmh_pkg::KEY_W-1:0] heap_keys [CAPACITY];
  int                        heap_fill;
  heap_result_t              owed_results [$];
  int                        mismatches;

  function automatic logic key_below(logic [bmh_pkg::KEY_W-1:0] a,
                                     logic [bmh_pkg::KEY_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [bmh_pkg::KEY_W-1:0] t;
    t            = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  // Move an entry toward the root while it is strictly smaller than its parent.
  function automatic void bubble_up(int i);
    int p;
    bit done;
    done = 1'b0;
    while (i != 0 && !done) begin
      p = (i - 1) / 2;
      if (key_below(heap_keys[i], heap_keys[p])) begin
        swap_slots(i, p);
        i = p;
      end else begin
        done = 1'b1;
      end
    end
  endfunction

  // Push an entry down toward its strictly smaller child, left child first.
  function automatic void bubble_down(int i);
    int l;
    int r;
    int s;
    bit done;
    done = 1'b0;
    while (!done) begin
      l = 2 * i + 1;
      r = l + 1;
      s = i;
      if (l < heap_fill && key_below(heap_keys[l], heap_keys[s])) s = l;
      if (r < heap_fill && key_below(heap_keys[r], heap_keys[s])) s = r;
      if (s == i) begin
        done = 1'b1;
      end else begin
        swap_slots(i, s);
        i = s;
      end
    end
  endfunction

  function automatic logic [bmh_pkg::KEY_W-1:0] take_min();
    logic [bmh_pkg::KEY_W-1:0] m;
    m            = heap_keys[0];
    heap_keys[0] = heap_keys[heap_fill-1];
    heap_fill--;
    bubble_down(0);
    return m;
  endfunction

  // Apply one request to the shadow heap and return the result it must give.
  function automatic heap_result_t predict_heap_result(bmh_pkg::kind_e kind,
                                                       logic [bmh_pkg::KEY_W-1:0] key,
                                                       int pos);
    heap_result_t r;
    int i;
    r.value  = '0;
    r.status = bmh_pkg::ST_OK;
    case (kind)
      bmh_pkg::KIND_INSERT: begin
        if (heap_fill >= CAPACITY) begin
          r.status = bmh_pkg::ST_FULL;
        end else begin
          heap_keys[heap_fill] = key;
          heap_fill++;
          bubble_up(heap_fill - 1);
        end
      end
      bmh_pkg::KIND_EXTRACT: begin
        if (heap_fill == 0) begin
          r.value  = '1;
          r.status = bmh_pkg::ST_EMPTY;
        end else begin
          r.value = take_min();
        end
      end
      bmh_pkg::KIND_DELETE: begin
        if (pos >= heap_fill) begin
          r.status = bmh_pkg::ST_BADIDX;
        end else begin
          // The doomed entry climbs to the root unconditionally.
          i = pos;
          heap_keys[i] = MOST_NEG_KEY;
          while (i != 0) begin
            swap_slots(i, (i - 1) / 2);
            i = (i - 1) / 2;
          end
          void'(take_min());
        end
      end
      default: begin
      end
    endcase
    r.count = bmh_pkg::COUNT_W'(heap_fill);
    return r;
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  // Results are retired before new requests are predicted on the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t got;
    heap_result_t want;
    if (!rst_ni) begin
      heap_fill = 0;
      owed_results.delete();
      mismatches = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.value  = m_tdata_i[bmh_pkg::KEY_W-1:0];
        got.status = bmh_pkg::status_e'(m_tdata_i[bmh_pkg::KEY_W +: bmh_pkg::STATUS_W]);
        got.count  = m_tdata_i[bmh_pkg::KEY_W+bmh_pkg::STATUS_W +: bmh_pkg::COUNT_W];
        if (owed_results.size() == 0) begin
          note_failure($sformatf("unexpected result value=%0d status=%s count=%0d",
                                 $signed(got.value), got.status.name(), got.count));
        end else begin
          want = owed_results.pop_front();
          if (got !== want) begin
            note_failure({$sformatf("result mismatch: expected value=%0d status=%s count=%0d",
                                    $signed(want.value), want.status.name(), want.count),
                          $sformatf(", got value=%0d status=%s count=%0d",
                                    $signed(got.value), got.status.name(), got.count)});
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        owed_results.push_back(predict_heap_result(
          bmh_pkg::kind_e'(s_tuser_i),
          s_tdata_i[bmh_pkg::KEY_W-1:0],
          int'(s_tdata_i[bmh_pkg::KEY_W +: bmh_pkg::POS_W])));
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= owed_results.size();
    fill_o       <= heap_fill;
  end

endmodule

// ===== sim/tb_top.sv =====
// Drives random heap requests into the block, stalls both channels at random
// and reports the verdict from the checker's failure count.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 64;
  localparam int REQUESTS = 900;
  localparam logic [bmh_pkg::KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
  localparam logic [bmh_pkg::KEY_W-1:0] KEY_MIN = 32'h8000_0001;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [bmh_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [bmh_pkg::KIND_W-1:0]     s_tuser = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [bmh_pkg::OUT_DATA_W-1:0] m_tdata;

  int fail_count;
  int pending;
  int fill_now;
  int sent = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int rx_wait = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  binary_min_heap_top #(.CAPACITY(CAPACITY)) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  heap_result_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .fill_o       (fill_now)
  );

  // Result side: after each accepted result, hold tready low for a random gap.
  always @(posedge clk) begin
    if (rst_n) begin
      if (m_tready && m_tvalid) begin
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 15);
        if (rx_wait != 0) m_tready <= 1'b0;
      end else if (!m_tready) begin
        if (rx_wait <= 1) m_tready <= 1'b1;
        else rx_wait--;
      end
    end
  end

  // Keys: wide random values, a narrow band full of duplicates, and the extremes.
  function automatic logic [bmh_pkg::KEY_W-1:0] draw_key();
    logic [bmh_pkg::KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: k = $urandom;
      5, 6, 7:       k = bmh_pkg::KEY_W'(int'($urandom_range(0, 16)) - 8);
      default: begin
        case ($urandom_range(0, 3))
          0:       k = KEY_MAX;
          1:       k = KEY_MIN;
          2:       k = '0;
          default: k = '1;
        endcase
      end
    endcase
    if (k == {1'b1, {(bmh_pkg::KEY_W-1){1'b0}}}) k = KEY_MIN;
    return k;
  endfunction

  // Present one request after a random gap and wait until it is taken.
  task automatic send_request(bmh_pkg::kind_e kind, logic [bmh_pkg::KEY_W-1:0] key,
                              logic [bmh_pkg::POS_W-1:0] pos);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, pos, key};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One random request; ins_pct sets how strongly the heap grows.
  task automatic send_random(int ins_pct);
    int r;
    logic [bmh_pkg::POS_W-1:0] pos;
    r   = $urandom_range(0, 99);
    pos = bmh_pkg::POS_W'($urandom_range(0, (1 << bmh_pkg::POS_W) - 1));
    if (r < 2) begin
      send_request(bmh_pkg::KIND_NONE, $urandom, pos);
    end else if (r < ins_pct) begin
      send_request(bmh_pkg::KIND_INSERT, draw_key(), pos);
    end else if ($urandom_range(0, 1) == 0) begin
      send_request(bmh_pkg::KIND_EXTRACT, $urandom, pos);
    end else begin
      // Mostly live positions, sometimes any position at all.
      if (fill_now > 0 && $urandom_range(0, 6) != 0)
        pos = bmh_pkg::POS_W'($urandom_range(0, fill_now - 1));
      send_request(bmh_pkg::KIND_DELETE, $urandom, pos);
    end
  endtask

  initial begin
    int phase_len;
    int ins_pct;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty heap: extract, delete and the unused kind.
    send_request(bmh_pkg::KIND_EXTRACT, '0, '0);
    send_request(bmh_pkg::KIND_DELETE, '0, '0);
    send_request(bmh_pkg::KIND_NONE, '1, '1);
    // Extreme and equal keys.
    send_request(bmh_pkg::KIND_INSERT, KEY_MAX, '0);
    send_request(bmh_pkg::KIND_INSERT, KEY_MIN, '1);
    send_request(bmh_pkg::KIND_INSERT, '0, '0);
    send_request(bmh_pkg::KIND_INSERT, '1, '0);
    send_request(bmh_pkg::KIND_INSERT, 32'd5, '0);
    send_request(bmh_pkg::KIND_INSERT, 32'd5, '0);
    send_request(bmh_pkg::KIND_INSERT, 32'd5, '0);
    // Positions at and past the count, then the last, the root and a middle one.
    send_request(bmh_pkg::KIND_DELETE, '0, bmh_pkg::POS_W'(7));
    send_request(bmh_pkg::KIND_DELETE, '0, '1);
    send_request(bmh_pkg::KIND_DELETE, '0, bmh_pkg::POS_W'(6));
    send_request(bmh_pkg::KIND_DELETE, '0, '0);
    send_request(bmh_pkg::KIND_DELETE, '0, bmh_pkg::POS_W'(2));
    send_request(bmh_pkg::KIND_NONE, '0, '0);
    // Drain the remaining four keys, then extract once more from empty.
    repeat (5) send_request(bmh_pkg::KIND_EXTRACT, '0, '0);

    // Fill to capacity and beyond, then delete the last slot of a full heap.
    repeat (CAPACITY + 6) send_request(bmh_pkg::KIND_INSERT, draw_key(),
                                       bmh_pkg::POS_W'($urandom));
    send_request(bmh_pkg::KIND_DELETE, '0, bmh_pkg::POS_W'(CAPACITY - 1));
    wait_drained();

    // Random phases that grow, shrink or churn the heap.
    while (sent < REQUESTS) begin
      phase_len = $urandom_range(30, 120);
      case ($urandom_range(0, 2))
        0:       ins_pct = 85;
        1:       ins_pct = 25;
        default: ins_pct = 55;
      endcase
      repeat (phase_len) begin
        if (sent < REQUESTS) send_random(ins_pct);
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("** binary_min_heap_top: PASSED **");
    end else begin
      $display("** binary_min_heap_top: FAILED **");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #5_000_000;
    $display("** binary_min_heap_top: FAILED **");
    $finish;
  end

endmodule
